// ===== hw/rtl/smcd_pkg.sv =====
// Shared types and constants for the serial motor command decoder.
// Depends on nothing; imported by serial_motor_command_decoder.
package smcd_pkg;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_END    = 4'b1000
  } phase_t;

  localparam logic [7:0] CHR_NL    = 8'd10;
  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_PLUS  = 8'd43;
  localparam logic [7:0] CHR_MINUS = 8'd45;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;

  localparam logic [7:0] CMD_LEFT_DRV   = 8'h73; // s
  localparam logic [7:0] CMD_RIGHT_DRV  = 8'h53; // S
  localparam logic [7:0] CMD_TUR_L_ON   = 8'h4C; // L
  localparam logic [7:0] CMD_TUR_L_OFF  = 8'h6C; // l
  localparam logic [7:0] CMD_TUR_R_ON   = 8'h50; // P
  localparam logic [7:0] CMD_TUR_R_OFF  = 8'h70; // p
  localparam logic [7:0] CMD_BUZ_ON     = 8'h48; // H
  localparam logic [7:0] CMD_BUZ_OFF    = 8'h68; // h

  localparam logic [7:0] PWM_MAX_RST = 8'd165;
  localparam logic [6:0] MAG_SAT     = 7'd100;

  // floor(x/100) == (x*5243) >> 19 for x < 43699; x here is at most 100*255
  localparam int         RECIP_SHIFT = 19;
  localparam int         SCALE_W     = 21;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(165 * 5243);

  localparam logic [0:0] REG_PWM_MAX = 1'b0;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

endpackage

// ===== hw/rtl/serial_motor_command_decoder.sv =====
// Serial motor command decoder top level.
// Depends on smcd_pkg (types, character codes, scaling constants).
//
// Takes one received byte per handshake and answers every byte with exactly one
// result word holding the current drive, turret and buzzer levels; line_done
// marks every received newline. Each byte is parsed combinationally between
// the input handshake and the result register, so one byte is accepted per
// clock for as long as results are taken. Duty is pwm_max*|v|/100: the APB
// write of pwm_max also stores pwm_max times the scaled reciprocal of 100, so
// the newline needs only one 7x21 multiply.
module serial_motor_command_decoder
  import smcd_pkg::*;
#(
  parameter int MAX_LINE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_left_duty,
  output logic        out_left_reverse,
  output logic [7:0]  out_right_duty,
  output logic        out_right_reverse,
  output logic        out_turret_left,
  output logic        out_turret_right,
  output logic        out_buzzer_on,
  output logic        out_line_done,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int POS_W = $clog2(MAX_LINE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);
  localparam logic [POS_W-1:0] POS_NUM  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(3);

  logic [7:0]         pwm_max_r;
  logic [SCALE_W-1:0] scale_r;

  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [7:0]       letter_r, letter_nxt;
  phase_t           phase_r,  phase_nxt;
  logic             neg_r,    neg_nxt;
  logic [6:0]       mag_r,    mag_nxt;
  logic [7:0]       ldut_r,   ldut_nxt;
  logic             lrev_r,   lrev_nxt;
  logic [7:0]       rdut_r,   rdut_nxt;
  logic             rrev_r,   rrev_nxt;
  logic             tl_r,     tl_nxt;
  logic             tr_r,     tr_nxt;
  logic             buz_r,    buz_nxt;
  logic             done_r,   done_nxt;
  logic             out_valid_r;

  logic               accept;
  logic               cfg_wr;
  logic [6:0]         mag_eff;
  logic               neg_eff;
  logic [SCALE_W+6:0] prod;
  logic [7:0]         duty;
  logic               drv_rev;
  logic [9:0]         acc;
  logic [7:0]         b;

  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_PWM_MAX) ? {24'd0, pwm_max_r} : 32'd0;

  assign b       = in_rx_byte;
  assign mag_eff = (pos_r < POS_FULL) ? 7'd0 : mag_r;
  assign neg_eff = (pos_r < POS_FULL) ? 1'b0 : neg_r;
  assign prod    = (SCALE_W + 7)'(mag_eff) * (SCALE_W + 7)'(scale_r);
  assign duty    = prod[RECIP_SHIFT +: 8];
  assign drv_rev = !((mag_eff != 7'd0) && !neg_eff);
  assign acc     = (10'(mag_r) << 3) + (10'(mag_r) << 1) + 10'(b - CHR_ZERO);

  always_comb begin
    pos_nxt    = pos_r;
    letter_nxt = letter_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    ldut_nxt   = ldut_r;
    lrev_nxt   = lrev_r;
    rdut_nxt   = rdut_r;
    rrev_nxt   = rrev_r;
    tl_nxt     = tl_r;
    tr_nxt     = tr_r;
    buz_nxt    = buz_r;
    done_nxt   = 1'b0;
    if (b == CHR_NL) begin
      done_nxt = 1'b1;
      if (pos_r != '0) begin
        unique case (letter_r)
          CMD_LEFT_DRV: begin
            ldut_nxt = duty;
            lrev_nxt = drv_rev;
          end
          CMD_RIGHT_DRV: begin
            rdut_nxt = duty;
            rrev_nxt = drv_rev;
          end
          CMD_TUR_L_ON:  tl_nxt  = 1'b1;
          CMD_TUR_L_OFF: tl_nxt  = 1'b0;
          CMD_TUR_R_ON:  tr_nxt  = 1'b1;
          CMD_TUR_R_OFF: tr_nxt  = 1'b0;
          CMD_BUZ_ON:    buz_nxt = 1'b1;
          CMD_BUZ_OFF:   buz_nxt = 1'b0;
          default: ;
        endcase
        if (tl_nxt && tr_nxt) begin
          tl_nxt = 1'b0;
          tr_nxt = 1'b0;
        end
      end
      pos_nxt    = '0;
      letter_nxt = 8'd0;
      phase_nxt  = PH_START;
      neg_nxt    = 1'b0;
      mag_nxt    = 7'd0;
    end else if (pos_r != POS_LAST) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r == '0) begin
        letter_nxt = b;
      end else if (pos_r >= POS_NUM) begin
        if (phase_r == PH_START && is_blank(b)) begin
          phase_nxt = PH_START;
        end else if (phase_r == PH_START && (b == CHR_PLUS || b == CHR_MINUS)) begin
          neg_nxt   = (b == CHR_MINUS);
          phase_nxt = PH_SIGN;
        end else if (phase_r != PH_END && is_digit(b)) begin
          mag_nxt   = (acc > 10'(MAG_SAT)) ? MAG_SAT : acc[6:0];
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_END;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_max_r <= PWM_MAX_RST;
      scale_r   <= SCALE_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_PWM_MAX) begin
      pwm_max_r <= cfg_pwdata[7:0];
      scale_r   <= SCALE_W'(cfg_pwdata[7:0]) * SCALE_W'(RECIP_100);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      letter_r    <= 8'd0;
      phase_r     <= PH_START;
      neg_r       <= 1'b0;
      mag_r       <= 7'd0;
      ldut_r      <= 8'd0;
      lrev_r      <= 1'b0;
      rdut_r      <= 8'd0;
      rrev_r      <= 1'b0;
      tl_r        <= 1'b0;
      tr_r        <= 1'b0;
      buz_r       <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r    <= pos_nxt;
        letter_r <= letter_nxt;
        phase_r  <= phase_nxt;
        neg_r    <= neg_nxt;
        mag_r    <= mag_nxt;
        ldut_r   <= ldut_nxt;
        lrev_r   <= lrev_nxt;
        rdut_r   <= rdut_nxt;
        rrev_r   <= rrev_nxt;
        tl_r     <= tl_nxt;
        tr_r     <= tr_nxt;
        buz_r    <= buz_nxt;
        done_r   <= done_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_duty     = ldut_r;
  assign out_left_reverse  = lrev_r;
  assign out_right_duty    = rdut_r;
  assign out_right_reverse = rrev_r;
  assign out_turret_left   = tl_r;
  assign out_turret_right  = tr_r;
  assign out_buzzer_on     = buz_r;
  assign out_line_done     = done_r;

endmodule
